>>> src/izn_pkg.sv
package izn_pkg;

    localparam int FRAC_BITS = 16;
    localparam logic signed [31:0] MAX_EXC_CONDUCTANCE = 32'sd65536;
    localparam logic signed [31:0] MAX_INH_CONDUCTANCE = 32'sd65536;
    localparam logic signed [63:0] C004 = 64'(((64'sd4 <<< FRAC_BITS) + 64'sd50) / 64'sd100);
    localparam logic signed [63:0] C140 = 64'sd140 <<< FRAC_BITS;
    localparam logic signed [63:0] C80 = 64'sd80 <<< FRAC_BITS;
    localparam logic signed [63:0] C10 = 64'sd10 <<< FRAC_BITS;
    localparam logic signed [31:0] V_RESET = 32'(-(64'sd60 <<< FRAC_BITS));

    localparam logic [3:0] REG_STEP_DT = 4'd0;
    localparam logic [3:0] REG_THRESHOLD = 4'd1;
    localparam logic [3:0] REG_RESET_POT = 4'd2;
    localparam logic [3:0] REG_REC_RATE = 4'd3;
    localparam logic [3:0] REG_REC_SENS = 4'd4;
    localparam logic [3:0] REG_REC_JUMP = 4'd5;
    localparam logic [3:0] REG_EXC_DECAY = 4'd6;
    localparam logic [3:0] REG_INH_DECAY = 4'd7;

    typedef struct packed {
        logic [7:0]  neuron_index;
        logic [30:0] exc_weight;
        logic [30:0] inh_weight;
    } t_in_word;

    typedef struct packed {
        logic [7:0]         neuron_number;
        logic               spiked;
        logic signed [31:0] membrane_potential;
        logic               large_step;
    } t_out_word;

    typedef struct packed {
        logic signed [31:0] v;
        logic signed [31:0] u;
        logic signed [31:0] ge;
        logic signed [31:0] gi;
    } t_state;

    typedef struct packed {
        logic [30:0]        step_dt;
        logic signed [31:0] spike_threshold;
        logic signed [31:0] reset_potential;
        logic [30:0]        recovery_rate;
        logic signed [31:0] recovery_sensitivity;
        logic signed [31:0] recovery_jump;
        logic [16:0]        exc_decay;
        logic [16:0]        inh_decay;
    } t_cfg;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic logic signed [31:0] fmul(input logic signed [31:0] x,
                                                input logic signed [31:0] y);
        logic signed [63:0] p;
        p = 64'(x) * 64'(y);
        return sat32(p >>> FRAC_BITS);
    endfunction

endpackage

>>> src/izn_ram.sv
module izn_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/izn_core.sv
module izn_core #(
    parameter int AW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  izn_pkg::t_cfg     i_cfg,
    input  logic              i_vld,
    input  logic [AW-1:0]     i_idx,
    input  logic [30:0]       i_ew,
    input  logic [30:0]       i_iw,
    input  izn_pkg::t_state   i_st,
    output logic              o_we,
    output logic [AW-1:0]     o_waddr,
    output izn_pkg::t_state   o_wdata,
    output logic              o_valid,
    output izn_pkg::t_out_word o_word
);
    logic               r2_vld, r3_vld, r4_vld, r5_vld, r6_vld, r_ovld;
    logic [AW-1:0]      r2_idx, r3_idx, r4_idx, r5_idx, r6_idx;
    logic signed [31:0] r2_v, r2_u, r2_ge, r2_gi, r2_vdi;
    logic signed [31:0] r3_v, r3_u, r3_ge, r3_gi, r3_p1, r3_p2, r3_p3, r3_p4, r3_de, r3_di;
    logic signed [31:0] r4_v, r4_u, r4_q1, r4_r, r4_ge, r4_gi, r4_p2, r4_p3;
    logic signed [31:0] r5_v, r5_u, r5_f, r5_m2, r5_m3, r5_ar, r5_ge, r5_gi;
    logic signed [31:0] r6_v, r6_u, r6_mf, r6_mu, r6_m2, r6_m3, r6_ge, r6_gi;
    logic signed [31:0] dt, ge_dec, gi_dec, vn, un, ujump, n_ge, n_gi;
    logic signed [63:0] diff;
    logic               spk, big;
    izn_pkg::t_out_word r_word;

    assign dt = $signed({1'b0, i_cfg.step_dt});

    always_comb begin
        ge_dec = izn_pkg::sat32(64'(r3_ge) - 64'(r3_de));
        gi_dec = izn_pkg::sat32(64'(r3_gi) - 64'(r3_di));
        n_ge = (ge_dec > izn_pkg::MAX_EXC_CONDUCTANCE) ? izn_pkg::MAX_EXC_CONDUCTANCE : ge_dec;
        n_gi = (gi_dec > izn_pkg::MAX_INH_CONDUCTANCE) ? izn_pkg::MAX_INH_CONDUCTANCE : gi_dec;
    end

    always_ff @(posedge i_clk) begin
        r2_idx <= i_idx;
        r2_v   <= i_st.v;
        r2_u   <= i_st.u;
        r2_ge  <= izn_pkg::sat32(64'(i_st.ge) + 64'(i_ew));
        r2_gi  <= izn_pkg::sat32(64'(i_st.gi) + 64'(i_iw));
        r2_vdi <= izn_pkg::sat32(64'(i_st.v) + izn_pkg::C80);

        r3_idx <= r2_idx;
        r3_v   <= r2_v;
        r3_u   <= r2_u;
        r3_ge  <= r2_ge;
        r3_gi  <= r2_gi;
        r3_p1  <= izn_pkg::fmul(r2_v, r2_v);
        r3_p2  <= izn_pkg::fmul(r2_ge, r2_v);
        r3_p3  <= izn_pkg::fmul(r2_gi, r2_vdi);
        r3_p4  <= izn_pkg::fmul(i_cfg.recovery_sensitivity, r2_v);
        r3_de  <= izn_pkg::fmul(r2_ge, $signed({15'd0, i_cfg.exc_decay}));
        r3_di  <= izn_pkg::fmul(r2_gi, $signed({15'd0, i_cfg.inh_decay}));

        r4_idx <= r3_idx;
        r4_v   <= r3_v;
        r4_u   <= r3_u;
        r4_q1  <= izn_pkg::fmul(32'(izn_pkg::C004), r3_p1);
        r4_r   <= izn_pkg::sat32(64'(r3_p4) - 64'(r3_u));
        r4_ge  <= n_ge;
        r4_gi  <= n_gi;
        r4_p2  <= r3_p2;
        r4_p3  <= r3_p3;

        r5_idx <= r4_idx;
        r5_v   <= r4_v;
        r5_u   <= r4_u;
        r5_f   <= izn_pkg::sat32(64'(r4_q1) + 64'sd5 * 64'(r4_v) + izn_pkg::C140 - 64'(r4_u));
        r5_m2  <= izn_pkg::fmul(dt, r4_p2);
        r5_m3  <= izn_pkg::fmul(dt, r4_p3);
        r5_ar  <= izn_pkg::fmul($signed({1'b0, i_cfg.recovery_rate}), r4_r);
        r5_ge  <= r4_ge;
        r5_gi  <= r4_gi;

        r6_idx <= r5_idx;
        r6_v   <= r5_v;
        r6_u   <= r5_u;
        r6_mf  <= izn_pkg::fmul(dt, r5_f);
        r6_mu  <= izn_pkg::fmul(dt, r5_ar);
        r6_m2  <= r5_m2;
        r6_m3  <= r5_m3;
        r6_ge  <= r5_ge;
        r6_gi  <= r5_gi;

        r_word <= '{neuron_number: 8'(r6_idx), spiked: spk,
                    membrane_potential: spk ? i_cfg.reset_potential : vn,
                    large_step: big};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            r2_vld <= i_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
            r_ovld <= r6_vld;
        end
    end

    always_comb begin
        vn    = izn_pkg::sat32(64'(r6_v) + 64'(r6_mf) - 64'(r6_m2) - 64'(r6_m3));
        un    = izn_pkg::sat32(64'(r6_u) + 64'(r6_mu));
        ujump = izn_pkg::sat32(64'(un) + 64'(i_cfg.recovery_jump));
        diff  = 64'(vn) - 64'(r6_v);
        big   = (diff > izn_pkg::C10) || (-diff > izn_pkg::C10);
        spk   = vn > i_cfg.spike_threshold;
    end

    assign o_we    = r6_vld;
    assign o_waddr = r6_idx;
    assign o_wdata = '{v: spk ? i_cfg.reset_potential : vn, u: spk ? ujump : un,
                       ge: r6_ge, gi: r6_gi};
    assign o_valid = r_ovld;
    assign o_word  = r_word;
endmodule

>>> src/izhikevich_neuron_array_step.sv
// Updates one Izhikevich neuron per accepted word, state held in a block RAM.
// A word is taken whenever busy is low; the result appears on o_word with
// o_valid high for one cycle, after stages r1 to r6 and the output register,
// and cannot be held off. Words for different neurons can follow every cycle.
// busy rises while a word for the same neuron is still in the 6-stage
// read-modify-write pipeline, so a neuron's next word waits for write-back.
// Out-of-range indexes wrap modulo NEURONS. Configuration writes take effect on
// the next edge and must be made while the pipeline is empty.
module izhikevich_neuron_array_step #(
    parameter int NEURONS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  izn_pkg::t_in_word   i_word,
    output logic                o_valid,
    output izn_pkg::t_out_word  o_word,
    input  logic                i_cfg_we,
    input  logic [3:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data
);
    localparam int AW = $clog2(NEURONS > 1 ? NEURONS : 2);
    localparam int DEPTH_STAGES = 6;

    izn_pkg::t_cfg   r_cfg;
    logic            accept;
    logic [AW-1:0]   req_idx;
    logic [31:0]     rem;
    logic            hazard;
    logic [DEPTH_STAGES-1:0] r_hz_vld;
    logic [AW-1:0]   r_hz_idx [DEPTH_STAGES];
    logic [NEURONS-1:0] r_init;
    logic            r1_init;
    logic [30:0]     r1_ew, r1_iw;
    logic [127:0]    rdata;
    izn_pkg::t_state st;
    logic            we;
    logic [AW-1:0]   waddr;
    izn_pkg::t_state wdata;

    always_comb begin
        rem = 32'(i_word.neuron_index);
        for (int k = 7; k >= 0; k--) begin
            if (64'(rem) >= (64'(NEURONS) << k)) begin
                rem = 32'(64'(rem) - (64'(NEURONS) << k));
            end
        end
        req_idx = rem[AW-1:0];
    end

    always_comb begin
        hazard = 1'b0;
        for (int s = 0; s < DEPTH_STAGES; s++) begin
            if (r_hz_vld[s] && (r_hz_idx[s] == req_idx)) begin
                hazard = 1'b1;
            end
        end
    end

    assign busy   = !i_rst_n || hazard;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{step_dt: 31'd6554, spike_threshold: -32'sd2621440,
                       reset_potential: -32'sd3932160, recovery_rate: 31'd1311,
                       recovery_sensitivity: 32'sd13107, recovery_jump: 32'sd524288,
                       exc_decay: 17'd1311, inh_decay: 17'd655};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                izn_pkg::REG_STEP_DT:   r_cfg.step_dt <= i_cfg_data[30:0];
                izn_pkg::REG_THRESHOLD: r_cfg.spike_threshold <= i_cfg_data;
                izn_pkg::REG_RESET_POT: r_cfg.reset_potential <= i_cfg_data;
                izn_pkg::REG_REC_RATE:  r_cfg.recovery_rate <= i_cfg_data[30:0];
                izn_pkg::REG_REC_SENS:  r_cfg.recovery_sensitivity <= i_cfg_data;
                izn_pkg::REG_REC_JUMP:  r_cfg.recovery_jump <= i_cfg_data;
                izn_pkg::REG_EXC_DECAY: r_cfg.exc_decay <= i_cfg_data[16:0];
                izn_pkg::REG_INH_DECAY: r_cfg.inh_decay <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hz_vld <= '0;
            r_init   <= '0;
        end else begin
            r_hz_vld <= {r_hz_vld[DEPTH_STAGES-2:0], accept};
            if (we) begin
                r_init[waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hz_idx[0] <= req_idx;
        for (int s = 1; s < DEPTH_STAGES; s++) begin
            r_hz_idx[s] <= r_hz_idx[s-1];
        end
        r1_init <= r_init[req_idx];
        r1_ew   <= i_word.exc_weight;
        r1_iw   <= i_word.inh_weight;
    end

    izn_ram #(.WIDTH(128), .DEPTH(NEURONS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(req_idx),
        .o_rdata(rdata)
    );

    assign st = r1_init ? izn_pkg::t_state'(rdata)
                        : '{v: izn_pkg::V_RESET, u: '0, ge: '0, gi: '0};

    izn_core #(.AW(AW)) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (r_cfg),
        .i_vld  (r_hz_vld[0]),
        .i_idx  (r_hz_idx[0]),
        .i_ew   (r1_ew),
        .i_iw   (r1_iw),
        .i_st   (st),
        .o_we   (we),
        .o_waddr(waddr),
        .o_wdata(wdata),
        .o_valid(o_valid),
        .o_word (o_word)
    );
endmodule

>>> src/izn_checker.sv
module izn_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);
    logic accepted;
    assign accepted = start && !busy;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accepted |-> ##7 o_valid)
        else $error("result missing after accepted word");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accepted, 7))
        else $error("result without accepted word");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");
endmodule

bind izhikevich_neuron_array_step izn_checker u_izn_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .start  (start),
    .busy   (busy),
    .o_valid(o_valid)
);
